[rtl/core/alq_pkg.sv]
// Shared types and constants for the delta-list alarm queue.
// No dependencies; imported by alq_flags, alq_ctrl and the top level.
package alq_pkg;

  // Width of a stored delta (signed, relative to the previous entry)
  localparam int DELTA_W  = 18;
  // Result handle width and free-slot scan group width
  localparam int HANDLE_W = 4;
  localparam int SCAN_W   = 16;
  localparam int SCAN_IW  = 4;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_SET      = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_TICK     = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_SET_DONE    = 3'd0,
    ST_FULL        = 3'd1,
    ST_CANCEL_DONE = 3'd2,
    ST_FIRED       = 3'd3,
    ST_EXP_CANCEL  = 3'd4,
    ST_TICK_IDLE   = 3'd5
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_WALK,
    S_WR_PREV,
    S_WR_NEW,
    S_CANCEL,
    S_TICK,
    S_T_HEAD,
    S_T_NEXT,
    S_LAST
  } state_t;

  // Slot flag update requested by the sequencer
  typedef struct packed {
    logic alloc;
    logic drop;
    logic mark;
  } flag_cmd_t;

endpackage

[rtl/core/alq_mem.sv]
// Entry memory of the alarm queue: one write port, one registered read port.
// Each entry holds a delta and a successor index. No package dependency.
module alq_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 22
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

[rtl/core/alq_flags.sv]
// Per-slot busy and cancel flags with a grouped lowest-free-slot search.
// Depends on alq_pkg for the flag command struct and scan constants.
module alq_flags
  import alq_pkg::*;
#(
  parameter int SLOTS = 16,
  parameter int IW    = 4,
  parameter int GW    = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  flag_cmd_t          cmd,
  input  logic [IW-1:0]      cmd_idx,
  input  logic [IW-1:0]      q_idx,
  output logic               q_cancelled,
  input  logic [GW-1:0]      grp_idx,
  output logic               grp_free,
  output logic [SCAN_IW-1:0] grp_pos
);

  localparam int NGRP = (SLOTS + SCAN_W - 1) / SCAN_W;

  logic [SLOTS-1:0]       busy_r;
  logic [SLOTS-1:0]       canc_r;
  logic [NGRP*SCAN_W-1:0] busy_pad;
  logic [SCAN_W-1:0]      grp;

  // Update flags: allocate, drop on expiry, mark a busy slot as cancelled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      canc_r <= '0;
    end else if (cmd.alloc) begin
      busy_r[cmd_idx] <= 1'b1;
      canc_r[cmd_idx] <= 1'b0;
    end else if (cmd.drop) begin
      busy_r[cmd_idx] <= 1'b0;
      canc_r[cmd_idx] <= 1'b0;
    end else if (cmd.mark && busy_r[cmd_idx]) begin
      canc_r[cmd_idx] <= 1'b1;
    end
  end

  assign q_cancelled = canc_r[q_idx];

  // Pad beyond the table as busy so the search never lands there
  always_comb begin
    busy_pad            = '1;
    busy_pad[SLOTS-1:0] = busy_r;
  end

  assign grp      = busy_pad[grp_idx*SCAN_W +: SCAN_W];
  assign grp_free = ~&grp;

  // Lowest free position within the selected group
  always_comb begin
    grp_pos = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (!grp[i]) begin
        grp_pos = SCAN_IW'(i);
      end
    end
  end

endmodule

[rtl/core/alq_ctrl.sv]
// Sequencer of the alarm queue: slot search, list walk, insertion, cancel,
// tick expiry and the result output register. Depends on alq_pkg.
module alq_ctrl
  import alq_pkg::*;
#(
  parameter int SLOTS    = 16,
  parameter int MAX_FIRE = 10,
  parameter int IW       = 4,
  parameter int GW       = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_operation,
  input  logic [15:0]           in_delay_ticks,
  input  logic [3:0]            in_target_slot,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic [HANDLE_W-1:0]   out_slot_handle,
  output logic                  out_last_of_run,
  // entry memory
  output logic                  mem_we,
  output logic [IW-1:0]         mem_waddr,
  output logic [DELTA_W+IW-1:0] mem_wdata,
  output logic                  mem_re,
  output logic [IW-1:0]         mem_raddr,
  input  logic [DELTA_W+IW-1:0] mem_rdata,
  // slot flags
  output flag_cmd_t             flag_cmd,
  output logic [IW-1:0]         flag_idx,
  output logic [IW-1:0]         flag_q_idx,
  input  logic                  flag_q_cancelled,
  output logic [GW-1:0]         grp_idx,
  input  logic                  grp_free,
  input  logic [SCAN_IW-1:0]    grp_pos
);

  localparam int NGRP = (SLOTS + SCAN_W - 1) / SCAN_W;
  localparam int FW   = $clog2(MAX_FIRE + 1);

  state_t                      state_r, state_nxt;
  logic                        nonempty_r, nonempty_nxt;
  logic [IW-1:0]               head_r, head_nxt;
  logic [15:0]                 delay_r, delay_nxt;
  logic [3:0]                  tgt_r, tgt_nxt;
  logic [GW-1:0]               g_r, g_nxt;
  logic [IW-1:0]               cur_r, cur_nxt;
  logic [IW-1:0]               prev_r, prev_nxt;
  logic signed [DELTA_W-1:0]   prev_delta_r, prev_delta_nxt;
  logic                        have_prev_r, have_prev_nxt;
  logic signed [DELTA_W-1:0]   d_r, d_nxt;
  logic [IW-1:0]               new_r, new_nxt;
  logic [IW-1:0]               new_next_r, new_next_nxt;
  logic [FW-1:0]               n_r, n_nxt;
  logic [FW-1:0]               n1;
  logic [IW-1:0]               pend_slot_r, pend_slot_nxt;
  logic                        pend_canc_r, pend_canc_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [2:0]                  out_status_r, out_status_nxt;
  logic [HANDLE_W-1:0]         out_handle_r, out_handle_nxt;
  logic                        out_last_r, out_last_nxt;

  logic signed [DELTA_W-1:0]   e_delta;
  logic [IW-1:0]               e_next;
  logic signed [DELTA_W-1:0]   dec;
  logic                        e_le0;
  logic                        out_free;
  logic                        tgt_ok;
  logic [IW-1:0]               found_slot;
  logic                        emit_req;
  status_t                     emit_status;
  logic [HANDLE_W-1:0]         emit_handle;
  logic                        emit_last;

  assign e_delta    = mem_rdata[IW +: DELTA_W];
  assign e_next     = mem_rdata[IW-1:0];
  assign dec        = e_delta - DELTA_W'(1);
  assign e_le0      = e_delta[DELTA_W-1] || (e_delta == '0);
  assign out_free   = !out_valid_r || out_ready;
  assign tgt_ok     = (32'(tgt_r) < SLOTS);
  assign found_slot = IW'({g_r, grp_pos});
  assign n1         = n_r + 1'b1;
  assign in_ready   = (state_r == S_IDLE);
  assign grp_idx    = g_r;
  assign flag_q_idx = cur_r;

  // Next state, memory and flag requests, result emission
  always_comb begin
    state_nxt      = state_r;
    nonempty_nxt   = nonempty_r;
    head_nxt       = head_r;
    delay_nxt      = delay_r;
    tgt_nxt        = tgt_r;
    g_nxt          = g_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    prev_delta_nxt = prev_delta_r;
    have_prev_nxt  = have_prev_r;
    d_nxt          = d_r;
    new_nxt        = new_r;
    new_next_nxt   = new_next_r;
    n_nxt          = n_r;
    pend_slot_nxt  = pend_slot_r;
    pend_canc_nxt  = pend_canc_r;
    mem_we         = 1'b0;
    mem_waddr      = cur_r;
    mem_wdata      = {e_delta, e_next};
    mem_re         = 1'b0;
    mem_raddr      = head_r;
    flag_cmd       = '0;
    flag_idx       = cur_r;
    emit_req       = 1'b0;
    emit_status    = ST_TICK_IDLE;
    emit_handle    = '0;
    emit_last      = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          delay_nxt = in_delay_ticks;
          tgt_nxt   = in_target_slot;
          unique case (op_t'(in_operation))
            OP_SET: begin
              g_nxt     = '0;
              state_nxt = S_FIND;
            end
            OP_CANCEL: state_nxt = S_CANCEL;
            OP_TICK:   state_nxt = S_TICK;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end

      // Search the busy flags one group a cycle
      S_FIND: begin
        if (grp_free) begin
          flag_cmd.alloc = 1'b1;
          flag_idx       = found_slot;
          new_nxt        = found_slot;
          new_next_nxt   = found_slot;
          d_nxt          = DELTA_W'(delay_r);
          have_prev_nxt  = 1'b0;
          if (nonempty_r) begin
            mem_re    = 1'b1;
            mem_raddr = head_r;
            cur_nxt   = head_r;
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_WR_NEW;
          end
        end else if (g_r == GW'(NGRP - 1)) begin
          emit_req    = 1'b1;
          emit_status = ST_FULL;
          if (out_free) begin
            state_nxt = S_IDLE;
          end
        end else begin
          g_nxt = g_r + 1'b1;
        end
      end

      // Walk the list, subtracting earlier deltas
      S_WALK: begin
        if (e_delta <= d_r) begin
          d_nxt          = d_r - e_delta;
          prev_nxt       = cur_r;
          prev_delta_nxt = e_delta;
          have_prev_nxt  = 1'b1;
          if (e_next == cur_r) begin
            mem_we       = 1'b1;
            mem_waddr    = cur_r;
            mem_wdata    = {e_delta, new_r};
            new_next_nxt = new_r;
            state_nxt    = S_WR_NEW;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = e_next;
            cur_nxt   = e_next;
          end
        end else begin
          mem_we       = 1'b1;
          mem_waddr    = cur_r;
          mem_wdata    = {DELTA_W'(e_delta - d_r), e_next};
          new_next_nxt = cur_r;
          state_nxt    = have_prev_r ? S_WR_PREV : S_WR_NEW;
        end
      end

      // Link the predecessor to the new entry
      S_WR_PREV: begin
        mem_we    = 1'b1;
        mem_waddr = prev_r;
        mem_wdata = {prev_delta_r, new_r};
        state_nxt = S_WR_NEW;
      end

      // Write the new entry and answer the set
      S_WR_NEW: begin
        emit_req    = 1'b1;
        emit_status = ST_SET_DONE;
        emit_handle = HANDLE_W'(new_r);
        if (out_free) begin
          mem_we       = 1'b1;
          mem_waddr    = new_r;
          mem_wdata    = {d_r, new_next_r};
          nonempty_nxt = 1'b1;
          if (!have_prev_r) begin
            head_nxt = new_r;
          end
          state_nxt = S_IDLE;
        end
      end

      S_CANCEL: begin
        emit_req    = 1'b1;
        emit_status = ST_CANCEL_DONE;
        emit_handle = tgt_r;
        if (out_free) begin
          flag_cmd.mark = tgt_ok;
          flag_idx      = IW'(tgt_r);
          state_nxt     = S_IDLE;
        end
      end

      // Fetch the head, or answer idle on an empty list
      S_TICK: begin
        if (nonempty_r) begin
          mem_re    = 1'b1;
          mem_raddr = head_r;
          cur_nxt   = head_r;
          n_nxt     = '0;
          state_nxt = S_T_HEAD;
        end else begin
          emit_req    = 1'b1;
          emit_status = ST_TICK_IDLE;
          if (out_free) begin
            state_nxt = S_IDLE;
          end
        end
      end

      // Decrement the head; write it back or pop it
      S_T_HEAD: begin
        if (!dec[DELTA_W-1] && (dec != '0)) begin
          emit_req    = 1'b1;
          emit_status = ST_TICK_IDLE;
          if (out_free) begin
            mem_we    = 1'b1;
            mem_waddr = cur_r;
            mem_wdata = {dec, e_next};
            state_nxt = S_IDLE;
          end
        end else begin
          flag_cmd.drop = 1'b1;
          pend_slot_nxt = cur_r;
          pend_canc_nxt = flag_q_cancelled;
          if (e_next == cur_r) begin
            nonempty_nxt = 1'b0;
            state_nxt    = S_LAST;
          end else begin
            head_nxt = e_next;
            if (n1 == FW'(MAX_FIRE)) begin
              state_nxt = S_LAST;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = e_next;
              cur_nxt   = e_next;
              n_nxt     = n1;
              state_nxt = S_T_NEXT;
            end
          end
        end
      end

      // Emit the held expiry; pop the next entry if it is due too
      S_T_NEXT: begin
        emit_req    = 1'b1;
        emit_status = pend_canc_r ? ST_EXP_CANCEL : ST_FIRED;
        emit_handle = HANDLE_W'(pend_slot_r);
        emit_last   = !e_le0;
        if (out_free) begin
          if (e_le0) begin
            flag_cmd.drop = 1'b1;
            pend_slot_nxt = cur_r;
            pend_canc_nxt = flag_q_cancelled;
            if (e_next == cur_r) begin
              nonempty_nxt = 1'b0;
              state_nxt    = S_LAST;
            end else begin
              head_nxt = e_next;
              if (n1 == FW'(MAX_FIRE)) begin
                state_nxt = S_LAST;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = e_next;
                cur_nxt   = e_next;
                n_nxt     = n1;
              end
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_LAST: begin
        emit_req    = 1'b1;
        emit_status = pend_canc_r ? ST_EXP_CANCEL : ST_FIRED;
        emit_handle = HANDLE_W'(pend_slot_r);
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Output register: drop a taken word, load a new one
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_last_nxt   = out_last_r;
    if (emit_req && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = emit_status;
      out_handle_nxt = emit_handle;
      out_last_nxt   = emit_last;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nonempty_r  <= 1'b0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nonempty_r  <= nonempty_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    delay_r      <= delay_nxt;
    tgt_r        <= tgt_nxt;
    g_r          <= g_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    prev_delta_r <= prev_delta_nxt;
    have_prev_r  <= have_prev_nxt;
    d_r          <= d_nxt;
    new_r        <= new_nxt;
    new_next_r   <= new_next_nxt;
    n_r          <= n_nxt;
    pend_slot_r  <= pend_slot_nxt;
    pend_canc_r  <= pend_canc_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_handle = out_handle_r;
  assign out_last_of_run = out_last_r;

`ifndef SYNTHESIS
  // The single memory port pair is never written and read in one cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("entry memory written and read in the same cycle");

  // The pop count stays below the limit while more expiries are checked
  a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_T_NEXT) |-> (n_r < FW'(MAX_FIRE)))
    else $error("expiry count reached its limit without stopping");

  // Only expiry words may continue a run
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |->
      (out_status_r == ST_FIRED || out_status_r == ST_EXP_CANCEL))
    else $error("non-expiry word without end of run");

  // The list only empties by popping its tail
  a_empty_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(nonempty_r) |->
      ($past(state_r) == S_T_HEAD || $past(state_r) == S_T_NEXT))
    else $error("list emptied outside of expiry");

  // A valid operation always starts work
  a_op_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation != OP_RESERVED) |=> (state_r != S_IDLE))
    else $error("accepted operation left the sequencer idle");
`endif

endmodule

[rtl/core/delta_list_alarm_queue.sv]
// Top level of the delta-list alarm queue: sequencer, slot flags and entry
// memory. Depends on alq_pkg, alq_mem, alq_flags and alq_ctrl.
//
//   channel | ports                                           | direction
//   input   | in_valid/in_ready, in_operation, in_delay_ticks,| in
//           | in_target_slot                                  |
//   result  | out_valid/out_ready, out_status,                | out
//           | out_slot_handle, out_last_of_run                |
//
// One item at a time, accepted only in idle. Set: a free-slot search in
// groups of 16 slots, a walk over the list entries, then writes of the
// changed and new entries. Tick: an idle answer on an empty list, else a
// head fetch and one result per expiry. A full output register stalls the
// sequencer in place; a new item is taken while the last result still waits.
// Synchronous reset clears the flags, the list head and the output register.
module delta_list_alarm_queue
  import alq_pkg::*;
#(
  parameter int SLOTS    = 16,
  parameter int MAX_FIRE = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_operation,
  input  logic [15:0]         in_delay_ticks,
  input  logic [3:0]          in_target_slot,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic [HANDLE_W-1:0] out_slot_handle,
  output logic                out_last_of_run
);

  localparam int IW   = $clog2(SLOTS);
  localparam int NGRP = (SLOTS + SCAN_W - 1) / SCAN_W;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int EW   = DELTA_W + IW;

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [EW-1:0]      mem_wdata;
  logic               mem_re;
  logic [IW-1:0]      mem_raddr;
  logic [EW-1:0]      mem_rdata;
  flag_cmd_t          flag_cmd;
  logic [IW-1:0]      flag_idx;
  logic [IW-1:0]      flag_q_idx;
  logic               flag_q_cancelled;
  logic [GW-1:0]      grp_idx;
  logic               grp_free;
  logic [SCAN_IW-1:0] grp_pos;

  // Sequencer and output register
  alq_ctrl #(
    .SLOTS    (SLOTS),
    .MAX_FIRE (MAX_FIRE),
    .IW       (IW),
    .GW       (GW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_delay_ticks   (in_delay_ticks),
    .in_target_slot   (in_target_slot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_slot_handle  (out_slot_handle),
    .out_last_of_run  (out_last_of_run),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata),
    .flag_cmd         (flag_cmd),
    .flag_idx         (flag_idx),
    .flag_q_idx       (flag_q_idx),
    .flag_q_cancelled (flag_q_cancelled),
    .grp_idx          (grp_idx),
    .grp_free         (grp_free),
    .grp_pos          (grp_pos)
  );

  // Busy and cancel flags
  alq_flags #(
    .SLOTS (SLOTS),
    .IW    (IW),
    .GW    (GW)
  ) u_flags (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (flag_cmd),
    .cmd_idx     (flag_idx),
    .q_idx       (flag_q_idx),
    .q_cancelled (flag_q_cancelled),
    .grp_idx     (grp_idx),
    .grp_free    (grp_free),
    .grp_pos     (grp_pos)
  );

  // Delta and successor store
  alq_mem #(
    .DEPTH (SLOTS),
    .AW    (IW),
    .DW    (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[bench/delta_list_alarm_queue_tb.sv]
// Self-checking bench for delta_list_alarm_queue: drives set, cancel and tick
// words with random gaps and stalls, and checks every result word against an
// internal delta-list predictor. Depends on alq_pkg and the block's RTL.
`timescale 1ns / 100ps

module delta_list_alarm_queue_tb;
  import alq_pkg::*;

  localparam int SLOTS       = 16;
  localparam int MAX_FIRE    = 10;
  localparam int N_WORDS     = 290;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 64;

  typedef struct {
    status_t      status;
    logic [3:0]   handle;
    logic         last;
  } alarm_result_t;

  // Alarm queue predictor with its queue of results still owed by the block
  class alarm_scoreboard;
    logic signed [DELTA_W-1:0] delta_q[SLOTS];
    logic [3:0]                next_q[SLOTS];
    bit                        busy_q[SLOTS];
    bit                        cancelled_q[SLOTS];
    logic [3:0]                head_q;
    bit                        nonempty_q;
    alarm_result_t             owed_q[$];
    int                        mismatches;

    function new();
      foreach (busy_q[i]) begin
        delta_q[i]     = '0;
        next_q[i]      = '0;
        busy_q[i]      = 1'b0;
        cancelled_q[i] = 1'b0;
      end
      head_q     = '0;
      nonempty_q = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void owe(status_t status, logic [3:0] handle, logic last);
      alarm_result_t r;
      r.status = status;
      r.handle = handle;
      r.last   = last;
      owed_q.push_back(r);
    endfunction

    // Link a slot into the delta list after all entries due at the same time
    function void link_slot(logic [3:0] slot, int d);
      logic [3:0] cur;
      logic [3:0] prev;
      bit         have_prev;
      bit         at_end;
      bit         walking;
      cur       = head_q;
      prev      = '0;
      have_prev = 1'b0;
      at_end    = 1'b0;
      walking   = 1'b1;
      if (!nonempty_q) begin
        delta_q[slot] = DELTA_W'(d);
        next_q[slot]  = slot;
        head_q        = slot;
        nonempty_q    = 1'b1;
        return;
      end
      for (int i = 0; i < SLOTS && walking; i++) begin
        if (delta_q[cur] <= d) begin
          d         = d - delta_q[cur];
          prev      = cur;
          have_prev = 1'b1;
          if (next_q[cur] == cur) begin
            at_end  = 1'b1;
            walking = 1'b0;
          end else begin
            cur = next_q[cur];
          end
        end else begin
          delta_q[cur] = DELTA_W'(delta_q[cur] - d);
          walking      = 1'b0;
        end
      end
      if (walking) at_end = 1'b1;
      delta_q[slot] = DELTA_W'(d);
      if (!have_prev) begin
        next_q[slot] = head_q;
        head_q       = slot;
      end else if (at_end) begin
        next_q[prev] = slot;
        next_q[slot] = slot;
      end else begin
        next_q[slot] = next_q[prev];
        next_q[prev] = slot;
      end
    endfunction

    // Advance the predictor by one accepted input word
    function void note_word(op_t op, logic [15:0] delay, logic [3:0] target);
      logic [3:0] free_slot;
      logic [3:0] s;
      bit         slot_found;
      int         fired;
      free_slot  = '0;
      slot_found = 1'b0;
      fired      = 0;
      case (op)
        OP_SET: begin
          for (int a = 0; a < SLOTS; a++) begin
            if (!slot_found && !busy_q[a]) begin
              free_slot  = 4'(a);
              slot_found = 1'b1;
            end
          end
          if (!slot_found) begin
            owe(ST_FULL, '0, 1'b1);
          end else begin
            busy_q[free_slot]      = 1'b1;
            cancelled_q[free_slot] = 1'b0;
            link_slot(free_slot, int'(delay));
            owe(ST_SET_DONE, free_slot, 1'b1);
          end
        end
        OP_CANCEL: begin
          if (busy_q[target]) cancelled_q[target] = 1'b1;
          owe(ST_CANCEL_DONE, target, 1'b1);
        end
        OP_TICK: begin
          if (nonempty_q) begin
            delta_q[head_q] = DELTA_W'(delta_q[head_q] - 1);
            while (nonempty_q && fired < MAX_FIRE && delta_q[head_q] <= 0) begin
              s = head_q;
              owe(cancelled_q[s] ? ST_EXP_CANCEL : ST_FIRED, s, 1'b0);
              busy_q[s]      = 1'b0;
              cancelled_q[s] = 1'b0;
              if (next_q[s] == s) nonempty_q = 1'b0;
              else head_q = next_q[s];
              fired++;
            end
          end
          if (fired == 0) owe(ST_TICK_IDLE, '0, 1'b1);
          else owed_q[owed_q.size() - 1].last = 1'b1;
        end
        default: ;  // reserved code: dropped by the block
      endcase
    endfunction

    // Compare a result word with the oldest owed result
    function void check_word(logic [2:0] status, logic [3:0] handle, logic last);
      alarm_result_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected result word: status %0d slot %0d last %0d",
               status, handle, last);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      if (status !== want.status) begin
        $error("out_status: expected %0d, got %0d", want.status, status);
        mismatches++;
      end
      if (handle !== want.handle) begin
        $error("out_slot_handle: expected %0d, got %0d", want.handle, handle);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("out_last_of_run: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  op_t         in_operation;
  logic [15:0] in_delay_ticks;
  logic [3:0]  in_target_slot;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [3:0]  out_slot_handle;
  logic        out_last_of_run;

  alarm_scoreboard sb = new();

  bit hold_results;
  bit send_back_to_back;
  bit watchdog_armed;
  int idle_cycles;
  int tx_run_left;
  int rx_run_left;

  delta_list_alarm_queue #(
    .SLOTS    (SLOTS),
    .MAX_FIRE (MAX_FIRE)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_delay_ticks  (in_delay_ticks),
    .in_target_slot  (in_target_slot),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_slot_handle (out_slot_handle),
    .out_last_of_run (out_last_of_run)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly random gaps, with occasional runs of no gap at all
  function automatic int draw_gap(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      run_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Observe both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_word(in_operation, in_delay_ticks, in_target_slot);
      if (out_valid && out_ready) sb.check_word(out_status, out_slot_handle, out_last_of_run);
    end
  end

  // End the run when neither channel moves a word for too long
  always @(posedge clk) begin
    if (watchdog_armed) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: stall at random, or hold off for a long stretch on request
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_results) begin
        stall        = HOLD_CYCLES;
        hold_results = 1'b0;
      end else begin
        stall = draw_gap(rx_run_left);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(op_t op, logic [15:0] delay, logic [3:0] target);
    int gap;
    gap = send_back_to_back ? 0 : draw_gap(tx_run_left);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_delay_ticks <= delay;
    in_target_slot <= target;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Mostly short-delay sets and ticks so alarms really expire; cancels aim at
  // live slots most of the time; a few long delays and reserved codes
  task automatic send_random_word(output bit counted);
    int         pick;
    int         k;
    logic [3:0] target;
    logic [3:0] start;
    logic [15:0] delay;
    pick    = $urandom_range(0, 99);
    delay   = 16'($urandom_range(0, 65535));
    target  = 4'($urandom_range(0, 15));
    counted = 1'b1;
    if (pick < 38) begin
      k = $urandom_range(0, 19);
      if (k < 15) delay = 16'($urandom_range(0, 6));
      else if (k < 18) delay = 16'($urandom_range(7, 300));
      send_word(OP_SET, delay, target);
    end else if (pick < 78) begin
      send_word(OP_TICK, delay, target);
    end else if (pick < 95) begin
      if ($urandom_range(0, 3) != 0) begin
        start = 4'($urandom_range(0, 15));
        for (int i = 0; i < SLOTS; i++) begin
          if (sb.busy_q[4'(start + i)]) target = 4'(start + i);
        end
      end
      send_word(OP_CANCEL, delay, target);
    end else begin
      counted = 1'b0;
      send_word(OP_RESERVED, delay, target);
    end
  endtask

  initial begin
    bit counted;
    int sent;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_operation      = OP_SET;
    in_delay_ticks    = '0;
    in_target_slot    = '0;
    hold_results      = 1'b0;
    send_back_to_back = 1'b0;
    watchdog_armed    = 1'b0;
    idle_cycles       = 0;
    tx_run_left       = 0;
    rx_run_left       = 0;
    repeat (3) @(negedge clk);
    rst_n          <= 1'b1;
    watchdog_armed <= 1'b1;
    @(negedge clk);

    // Idle tick, cancel of a free slot, reserved code
    send_word(OP_TICK, 16'h0000, 4'd0);
    send_word(OP_CANCEL, 16'hffff, 4'd15);
    send_word(OP_RESERVED, 16'h1234, 4'd7);
    // Zero delay, cancelled twice, then reuse of the expired slot
    send_word(OP_SET, 16'h0000, 4'd0);
    send_word(OP_CANCEL, 16'h0000, 4'd0);
    send_word(OP_CANCEL, 16'h0000, 4'd0);
    send_word(OP_TICK, 16'h0000, 4'd0);
    send_word(OP_SET, 16'hffff, 4'd15);
    // Fill the table with equal-time alarms, overflow it, and fire in two runs
    for (int i = 0; i < SLOTS - 1; i++) send_word(OP_SET, 16'h0000, 4'(i));
    send_word(OP_SET, 16'h0005, 4'd0);
    send_word(OP_TICK, 16'h0000, 4'd0);
    send_word(OP_TICK, 16'h0000, 4'd0);

    // Hold the result side off while words keep coming back to back
    hold_results      = 1'b1;
    send_back_to_back = 1'b1;
    for (int i = 0; i < 20; i++) send_random_word(counted);
    send_back_to_back = 1'b0;

    // Pause until every owed result has come out
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);

    sent = 0;
    while (sent < N_WORDS) begin
      send_random_word(counted);
      if (counted) sent++;
    end
    in_valid <= 1'b0;

    // Drain, then watch a little longer for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
